[rtl/pcl_pkg.sv]
// Shared types and constants for the press-code lock.
// Holds the request/response word layouts, command codes and register indexes.
// No dependencies.
package pcl_pkg;

   // Longest code the sequence register holds
   localparam int CODE_MAX = 16;
   localparam int CODE_W   = 16;
   localparam int LEN_W    = 5;
   localparam int MS_W     = 16;
   localparam int WIN_W    = 18;
   localparam int FAIL_W   = 8;
   localparam int SEC_W    = 8;
   localparam int MS_PER_S = 1000;

   // Command codes
   localparam logic [2:0] CMD_TICK    = 3'd0;
   localparam logic [2:0] CMD_START   = 3'd1;
   localparam logic [2:0] CMD_RESTART = 3'd2;
   localparam logic [2:0] CMD_LOCK    = 3'd3;
   localparam logic [2:0] CMD_ADMIN   = 3'd4;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_ENABLED   = 3'd0;
   localparam logic [2:0] REG_SHORT_MAX = 3'd1;
   localparam logic [2:0] REG_LONG_MIN  = 3'd2;
   localparam logic [2:0] REG_GAP_LIMIT = 3'd3;
   localparam logic [2:0] REG_TIMEOUT   = 3'd4;
   localparam logic [2:0] REG_RETRIES   = 3'd5;
   localparam logic [2:0] REG_CODE_BITS = 3'd6;
   localparam logic [2:0] REG_CODE_LEN  = 3'd7;

   typedef struct packed {
      logic [2:0]        cmd;
      logic              pressed;
      logic [CODE_W-1:0] pass_bits;
      logic [LEN_W-1:0]  pass_length;
   } req_word_type;

   typedef struct packed {
      logic              locked;
      logic              just_unlocked;
      logic              admin_accepted;
      logic [FAIL_W-1:0] retry_count;
      logic              entry_blocked;
   } rsp_word_type;

endpackage

[rtl/press_code_lock_core.sv]
// Press-code lock: decodes timed button presses into a code and unlocks on a match or an accepted admin passcode.
// Depends on pcl_pkg for word layouts, command codes and register indexes.
//
//   port group   direction  handshake           word
//   req_*        in         req_valid/req_stall  pcl_pkg::req_word_type
//   rsp_*        out        rsp_valid/rsp_stall  pcl_pkg::rsp_word_type
//   p* (APB)     in/out     psel/penable/pready  32-bit registers at 4*i
//
// One word per cycle sustained while the response does not stall; each word passes
// through the input register, then through the update logic into the response
// register. The lock state updates as the word moves into the response register.
// A stalled response holds; the input register keeps taking words while the
// response register is free or being drained. Reset is synchronous and clears
// the lock state, counters and registers to their defaults.
module press_code_lock_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcl_pkg::req_word_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcl_pkg::rsp_word_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [4:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import pcl_pkg::*;

   localparam logic [1:0] STAGE_IDLE  = 2'd0;
   localparam logic [1:0] STAGE_PRESS = 2'd1;
   localparam logic [1:0] STAGE_GAP   = 2'd2;

   localparam int IDX_W = $clog2(CODE_W);

   // Configuration registers
   logic              enabled_ff;
   logic [MS_W-1:0]   short_max_ff;
   logic [MS_W-1:0]   long_min_ff;
   logic [MS_W-1:0]   gap_limit_ff;
   logic [SEC_W-1:0]  timeout_ff;
   logic [FAIL_W-1:0] retries_ff;
   logic [CODE_W-1:0] code_bits_ff;
   logic [LEN_W-1:0]  code_len_ff;

   // Lock state
   logic              locked_ff, locked_in;
   logic [1:0]        stage_ff, stage_in;
   logic [MS_W-1:0]   press_ff, press_in;
   logic [MS_W-1:0]   gap_ff, gap_in;
   logic [CODE_W-1:0] seq_ff, seq_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [FAIL_W-1:0] fail_ff, fail_in;
   logic [WIN_W-1:0]  win_ff, win_in;

   // Pipeline registers
   logic              in_valid_ff;
   req_word_type      in_data_ff;
   logic              out_valid_ff;
   rsp_word_type      out_data_ff, out_data_in;

   logic              advance;
   logic              cfg_write;
   logic [2:0]        cfg_idx;

   logic [MS_W-1:0]   press_inc, gap_inc;
   logic [WIN_W-1:0]  win_inc, timeout_lim;
   logic [LEN_W-1:0]  eff_len;
   logic [CODE_W:0]   mask_wide;
   logic [CODE_W-1:0] code_mask;
   logic [FAIL_W-1:0] fail_inc;
   logic              timed_pre, retries_pre, timed_post, retries_post;
   logic              press_short, press_ok, seq_full;
   logic [CODE_W-1:0] seq_add, seq_rel;
   logic [LEN_W-1:0]  cnt_rel;
   logic              match_rel, match_cur, gap_ok, pass_ok;
   logic              pulse, admin;

   // ---------------------------------------------------------------- handshakes
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   // ---------------------------------------------------------------- registers
   assign pready    = 1'b1;
   assign cfg_idx   = paddr[4:2];
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         short_max_ff <= MS_W'(200);
         long_min_ff  <= MS_W'(400);
         gap_limit_ff <= MS_W'(1000);
         timeout_ff   <= '0;
         retries_ff   <= '0;
         code_bits_ff <= '0;
         code_len_ff  <= LEN_W'(4);
      end else if (cfg_write) begin
         case (cfg_idx)
            REG_ENABLED:   enabled_ff   <= pwdata[0];
            REG_SHORT_MAX: short_max_ff <= pwdata[MS_W-1:0];
            REG_LONG_MIN:  long_min_ff  <= pwdata[MS_W-1:0];
            REG_GAP_LIMIT: gap_limit_ff <= pwdata[MS_W-1:0];
            REG_TIMEOUT:   timeout_ff   <= pwdata[SEC_W-1:0];
            REG_RETRIES:   retries_ff   <= pwdata[FAIL_W-1:0];
            REG_CODE_BITS: code_bits_ff <= pwdata[CODE_W-1:0];
            REG_CODE_LEN:  code_len_ff  <= pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         REG_ENABLED:   prdata = 32'(enabled_ff);
         REG_SHORT_MAX: prdata = 32'(short_max_ff);
         REG_LONG_MIN:  prdata = 32'(long_min_ff);
         REG_GAP_LIMIT: prdata = 32'(gap_limit_ff);
         REG_TIMEOUT:   prdata = 32'(timeout_ff);
         REG_RETRIES:   prdata = 32'(retries_ff);
         REG_CODE_BITS: prdata = 32'(code_bits_ff);
         REG_CODE_LEN:  prdata = 32'(code_len_ff);
         default:       prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- update logic
   // Every word counts as one millisecond; counters saturate
   assign press_inc = (press_ff == '1) ? press_ff : press_ff + 1'b1;
   assign gap_inc   = (gap_ff == '1) ? gap_ff : gap_ff + 1'b1;
   assign win_inc   = (win_ff == '1) ? win_ff : win_ff + 1'b1;
   assign fail_inc  = (fail_ff == '1) ? fail_ff : fail_ff + 1'b1;

   assign timeout_lim = WIN_W'(WIN_W'(timeout_ff) * WIN_W'(MS_PER_S));
   assign eff_len     = (code_len_ff > LEN_W'(CODE_MAX)) ? LEN_W'(CODE_MAX) : code_len_ff;
   assign mask_wide   = (CODE_W+1)'(1) << eff_len;
   assign code_mask   = CODE_W'(mask_wide - 1'b1);

   assign timed_pre   = (timeout_ff != '0) && (win_inc > timeout_lim);
   assign retries_pre = (retries_ff != '0) && (fail_ff >= retries_ff);

   // Classify the press that ends on this tick; short wins when both limits apply
   assign press_short = press_inc < short_max_ff;
   assign press_ok    = press_short || (press_inc >= long_min_ff);
   assign seq_full    = cnt_ff >= LEN_W'(CODE_W);
   assign seq_add     = seq_ff | (CODE_W'(!press_short) << cnt_ff[IDX_W-1:0]);

   always_comb begin
      if (!press_ok) begin
         seq_rel = '0;
         cnt_rel = '0;
      end else if (seq_full) begin
         seq_rel = seq_ff;
         cnt_rel = cnt_ff;
      end else begin
         seq_rel = seq_add;
         cnt_rel = cnt_ff + 1'b1;
      end
   end

   assign match_rel = ((seq_rel ^ code_bits_ff) & code_mask) == '0;
   assign match_cur = ((seq_ff ^ code_bits_ff) & code_mask) == '0;
   assign gap_ok    = (cnt_ff != '0) && (cnt_ff == eff_len) && match_cur;
   assign pass_ok   = (in_data_ff.pass_length == eff_len) &&
                      (((in_data_ff.pass_bits ^ code_bits_ff) & code_mask) == '0);

   always_comb begin
      locked_in = locked_ff;
      stage_in  = stage_ff;
      press_in  = press_inc;
      gap_in    = gap_inc;
      win_in    = win_inc;
      seq_in    = seq_ff;
      cnt_in    = cnt_ff;
      fail_in   = fail_ff;
      pulse     = 1'b0;
      admin     = 1'b0;
      case (in_data_ff.cmd)
         CMD_TICK: begin
            if (!enabled_ff) begin
               locked_in = 1'b0;
            end else if (locked_ff && !timed_pre && !retries_pre) begin
               case (stage_ff)
                  STAGE_IDLE: begin
                     if (in_data_ff.pressed) begin
                        stage_in = STAGE_PRESS;
                        press_in = '0;
                     end
                  end
                  STAGE_PRESS: begin
                     if (!in_data_ff.pressed) begin
                        stage_in = STAGE_GAP;
                        gap_in   = '0;
                        seq_in   = seq_rel;
                        cnt_in   = cnt_rel;
                        if (cnt_rel >= eff_len) begin
                           if (match_rel) begin
                              locked_in = 1'b0;
                              pulse     = 1'b1;
                           end else begin
                              fail_in  = fail_inc;
                              seq_in   = '0;
                              cnt_in   = '0;
                              stage_in = STAGE_IDLE;
                              press_in = '0;
                           end
                        end
                     end
                  end
                  default: begin
                     if (in_data_ff.pressed) begin
                        stage_in = STAGE_PRESS;
                        press_in = '0;
                     end else if (gap_inc > gap_limit_ff) begin
                        if (gap_ok) begin
                           locked_in = 1'b0;
                           pulse     = 1'b1;
                        end else begin
                           // Partial sequence left hanging: count a failure
                           if (cnt_ff != '0) begin
                              fail_in  = fail_inc;
                              press_in = '0;
                           end
                           seq_in   = '0;
                           cnt_in   = '0;
                           stage_in = STAGE_IDLE;
                        end
                     end
                  end
               endcase
            end
         end
         CMD_START, CMD_RESTART, CMD_LOCK: begin
            if (in_data_ff.cmd == CMD_START) begin
               locked_in = enabled_ff;
               fail_in   = '0;
            end else if (in_data_ff.cmd == CMD_LOCK) begin
               locked_in = 1'b1;
               fail_in   = '0;
            end
            seq_in   = '0;
            cnt_in   = '0;
            stage_in = STAGE_IDLE;
            press_in = '0;
            win_in   = '0;
         end
         CMD_ADMIN: begin
            if (pass_ok) begin
               locked_in = 1'b0;
               pulse     = 1'b1;
               admin     = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign timed_post   = (timeout_ff != '0) && (win_in > timeout_lim);
   assign retries_post = (retries_ff != '0) && (fail_in >= retries_ff);

   always_comb begin
      out_data_in.locked         = locked_in;
      out_data_in.just_unlocked  = pulse;
      out_data_in.admin_accepted = admin;
      out_data_in.retry_count    = fail_in;
      out_data_in.entry_blocked  = enabled_ff && locked_in && (timed_post || retries_post);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff <= 1'b0;
         stage_ff  <= STAGE_IDLE;
         press_ff  <= '0;
         gap_ff    <= '0;
         seq_ff    <= '0;
         cnt_ff    <= '0;
         fail_ff   <= '0;
         win_ff    <= '0;
      end else if (advance) begin
         locked_ff <= locked_in;
         stage_ff  <= stage_in;
         press_ff  <= press_in;
         gap_ff    <= gap_in;
         seq_ff    <= seq_in;
         cnt_ff    <= cnt_in;
         fail_ff   <= fail_in;
         win_ff    <= win_in;
      end
   end

endmodule
